>>> hdl/mabi_pkg.sv
// ----------------------------------------------------------------------------
// mabi_pkg
// Shared types and constants for the multi-arm ack barrier interlock.
// ----------------------------------------------------------------------------
package mabi_pkg;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned MODE_W     = 5;
    localparam int unsigned FWD_W      = 8;
    localparam int unsigned MASK_W     = 32;
    localparam int unsigned ARMS_W     = 4;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    localparam logic [MASK_W-1:0] SAFE_MASK_RST = 32'd6;
    localparam logic [ARMS_W-1:0] ARMS_RST      = 4'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TRAJ = 2'd0,
        CMD_MODE = 2'd1,
        CMD_ACK  = 2'd2,
        CMD_TICK = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_SAFE_MASK = 1'b0,
        REG_ARMS      = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [FWD_W-1:0] forward_mask;
        logic             dropped;
        logic             combined_ack;
        logic             freeze_report;
        logic             freeze;
    } t_res;

endpackage

>>> hdl/mabi_evt_if.sv
// ----------------------------------------------------------------------------
// mabi_evt_if
// Event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
interface mabi_evt_if;
    logic                          valid;
    logic                          ready;
    logic [mabi_pkg::CMD_W-1:0]    cmd;
    logic [mabi_pkg::IDX_W-1:0]    arm_index;
    logic [mabi_pkg::MODE_W-1:0]   mode_num;
    logic                          trajectory_empty;

    modport source (output valid, output cmd, output arm_index, output mode_num,
                    output trajectory_empty, input ready);
    modport sink   (input valid, input cmd, input arm_index, input mode_num,
                    input trajectory_empty, output ready);
endinterface

>>> hdl/mabi_res_if.sv
// ----------------------------------------------------------------------------
// mabi_res_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface mabi_res_if;
    logic                          valid;
    logic                          ready;
    logic [mabi_pkg::FWD_W-1:0]    forward_mask;
    logic                          dropped;
    logic                          combined_ack;
    logic                          freeze_report;
    logic                          freeze;

    modport source (output valid, output forward_mask, output dropped,
                    output combined_ack, output freeze_report, output freeze,
                    input ready);
    modport sink   (input valid, input forward_mask, input dropped,
                    input combined_ack, input freeze_report, input freeze,
                    output ready);
endinterface

>>> hdl/multi_arm_ack_barrier_interlock.sv
// ----------------------------------------------------------------------------
// multi_arm_ack_barrier_interlock
// One event per cycle while the skid entry is empty. Each result is registered
// in a two-entry output skid (output stage and skid entry), which keeps input
// open while one result waits. Synchronous active-low reset clears all arm
// flags, in-flight and freeze state, and restores the register defaults.
// ----------------------------------------------------------------------------
module multi_arm_ack_barrier_interlock #(
    parameter int unsigned MAX_ARMS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mabi_evt_if.sink                            i_evt,
    mabi_res_if.source                          o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mabi_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mabi_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mabi_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam logic [mabi_pkg::CNT_W-1:0] MaxCnt = mabi_pkg::CNT_W'(MAX_ARMS);

    logic [mabi_pkg::MASK_W-1:0]  r_safe_mask;
    logic [mabi_pkg::ARMS_W-1:0]  r_arms;
    logic [mabi_pkg::MODE_W-1:0]  r_arm_mode [MAX_ARMS];
    logic [mabi_pkg::MODE_W-1:0]  n_arm_mode [MAX_ARMS];
    logic [MAX_ARMS-1:0]          r_seen,  n_seen;
    logic [MAX_ARMS-1:0]          r_acked, n_acked;
    logic                         r_in_flight, n_in_flight;
    logic                         r_frozen, n_frozen;

    mabi_pkg::t_res               r_out, r_skid, n_res;
    logic                         r_out_valid, r_skid_valid;

    logic                         w_accept, w_pop, w_cfg_wr;
    logic [mabi_pkg::CNT_W-1:0]   w_cnt, w_arms_ext, w_idx_ext;
    logic [MAX_ARMS-1:0]          w_act, w_safe, w_acks_new;
    logic                         w_all_safe, w_idx_ok;
    logic [mabi_pkg::FWD_W-1:0]   w_act_fwd;
    mabi_pkg::t_cmd               w_cmd;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (mabi_pkg::t_reg_idx'(paddr[2]) == mabi_pkg::REG_ARMS)
                    ? mabi_pkg::APB_DATA_W'(r_arms) : r_safe_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe_mask <= mabi_pkg::SAFE_MASK_RST;
            r_arms      <= mabi_pkg::ARMS_RST;
        end else if (w_cfg_wr) begin
            case (mabi_pkg::t_reg_idx'(paddr[2]))
                mabi_pkg::REG_SAFE_MASK: r_safe_mask <= pwdata;
                mabi_pkg::REG_ARMS:      r_arms      <= pwdata[mabi_pkg::ARMS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_arms_ext = mabi_pkg::CNT_W'(r_arms);
    assign w_cnt      = (w_arms_ext == '0) ? mabi_pkg::CNT_W'(1)
                      : ((w_arms_ext > MaxCnt) ? MaxCnt : w_arms_ext);
    assign w_idx_ext  = mabi_pkg::CNT_W'(i_evt.arm_index);
    assign w_idx_ok   = w_idx_ext < w_cnt;
    assign w_cmd      = mabi_pkg::t_cmd'(i_evt.cmd);

    always_comb begin
        for (int i = 0; i < MAX_ARMS; i++) begin
            w_act[i]  = mabi_pkg::CNT_W'(i) < w_cnt;
            w_safe[i] = r_seen[i] && r_safe_mask[r_arm_mode[i]];
            w_acks_new[i] = r_acked[i] || (w_idx_ext == mabi_pkg::CNT_W'(i));
        end
        for (int j = 0; j < mabi_pkg::FWD_W; j++) begin
            w_act_fwd[j] = mabi_pkg::CNT_W'(j) < w_cnt;
        end
    end

    assign w_all_safe = &(w_safe | ~w_act);

    always_comb begin
        n_arm_mode  = r_arm_mode;
        n_seen      = r_seen;
        n_acked     = r_acked;
        n_in_flight = r_in_flight;
        n_frozen    = r_frozen;
        n_res       = '0;
        case (w_cmd)
            mabi_pkg::CMD_TRAJ: begin
                if (i_evt.trajectory_empty) begin
                    n_res.forward_mask = w_act_fwd;
                    n_acked            = '0;
                    n_in_flight        = 1'b0;
                end else if (!w_all_safe) begin
                    n_res.dropped = 1'b1;
                end else begin
                    n_res.forward_mask = w_act_fwd;
                    n_acked            = '0;
                    n_in_flight        = 1'b1;
                end
            end
            mabi_pkg::CMD_MODE: begin
                for (int i = 0; i < MAX_ARMS; i++) begin
                    if (w_idx_ok && w_idx_ext == mabi_pkg::CNT_W'(i)) begin
                        n_arm_mode[i] = i_evt.mode_num;
                        n_seen[i]     = 1'b1;
                    end
                end
            end
            mabi_pkg::CMD_ACK: begin
                if (w_idx_ok && r_in_flight) begin
                    n_acked            = w_acks_new;
                    n_res.combined_ack = &(w_acks_new | ~w_act);
                end
            end
            mabi_pkg::CMD_TICK: begin
                if (!w_all_safe && !r_frozen) begin
                    n_frozen    = 1'b1;
                    n_in_flight = 1'b0;
                    n_acked     = '0;
                end else if (w_all_safe && r_frozen) begin
                    n_frozen = 1'b0;
                end
                n_res.freeze_report = 1'b1;
            end
            default: ;
        endcase
        n_res.freeze = n_frozen;
    end

    assign i_evt.ready = !r_skid_valid;
    assign w_accept    = i_evt.valid && !r_skid_valid;
    assign w_pop       = r_out_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ARMS; i++) begin
                r_arm_mode[i] <= '0;
            end
            r_seen      <= '0;
            r_acked     <= '0;
            r_in_flight <= 1'b0;
            r_frozen    <= 1'b0;
        end else if (w_accept) begin
            r_arm_mode  <= n_arm_mode;
            r_seen      <= n_seen;
            r_acked     <= n_acked;
            r_in_flight <= n_in_flight;
            r_frozen    <= n_frozen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (w_pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.forward_mask  = r_out.forward_mask;
    assign o_res.dropped       = r_out.dropped;
    assign o_res.combined_ack  = r_out.combined_ack;
    assign o_res.freeze_report = r_out.freeze_report;
    assign o_res.freeze        = r_out.freeze;

endmodule

>>> sim/mabi_checker.sv
// ----------------------------------------------------------------------------
// mabi_checker
// Watches the event, result and register ports of the interlock. It keeps its
// own copy of the arm flags and registers, works out the result of every
// accepted event and compares each accepted result, field by field, with the
// oldest outstanding prediction. Register reads are checked as well.
// ----------------------------------------------------------------------------
module mabi_checker
    import mabi_pkg::*;
#(
    parameter int unsigned MAX_ARMS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mabi_evt_if                   i_evt,
    mabi_res_if                   i_res,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic [APB_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    output int                    o_pending,
    output int                    o_fail_count
);

    logic [MASK_W-1:0] safe_mask;
    logic [ARMS_W-1:0] arms_cfg;
    logic [MODE_W-1:0] arm_mode  [MAX_ARMS];
    logic              mode_seen [MAX_ARMS];
    logic              arm_acked [MAX_ARMS];
    logic              in_flight;
    logic              frozen;

    t_res interlock_results[$];
    int   fail_count = 0;

    function automatic int unsigned active_arms();
        int unsigned n;
        n = 32'(arms_cfg);
        if (n < 1) n = 1;
        if (n > MAX_ARMS) n = MAX_ARMS;
        return n;
    endfunction

    function automatic logic group_safe();
        int unsigned n;
        n = active_arms();
        for (int i = 0; i < n; i++) begin
            if (!mode_seen[i] || !safe_mask[arm_mode[i]]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_acks();
        for (int i = 0; i < MAX_ARMS; i++) arm_acked[i] = 1'b0;
    endfunction

    function automatic t_res interlock_step(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                                            input logic [MODE_W-1:0] mode, input logic empty);
        t_res             r;
        int unsigned      n;
        logic [FWD_W-1:0] all_arms;
        logic             every_ack;
        logic             safe;
        r        = '0;
        n        = active_arms();
        all_arms = FWD_W'((32'd1 << n) - 32'd1);
        case (cmd)
            CMD_TRAJ: begin
                if (empty) begin
                    r.forward_mask = all_arms;
                    clear_acks();
                    in_flight = 1'b0;
                end else if (!group_safe()) begin
                    r.dropped = 1'b1;
                end else begin
                    clear_acks();
                    r.forward_mask = all_arms;
                    in_flight = 1'b1;
                end
            end
            CMD_MODE: begin
                if (32'(idx) < n) begin
                    arm_mode[idx]  = mode;
                    mode_seen[idx] = 1'b1;
                end
            end
            CMD_ACK: begin
                if (32'(idx) < n && in_flight) begin
                    arm_acked[idx] = 1'b1;
                    every_ack = 1'b1;
                    for (int i = 0; i < n; i++) begin
                        if (!arm_acked[i]) every_ack = 1'b0;
                    end
                    r.combined_ack = every_ack;
                end
            end
            default: begin
                safe = group_safe();
                if (!safe && !frozen) begin
                    frozen    = 1'b1;
                    in_flight = 1'b0;
                    clear_acks();
                end else if (safe && frozen) begin
                    frozen = 1'b0;
                end
                r.freeze_report = 1'b1;
            end
        endcase
        r.freeze = frozen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res             want;
        logic [APB_DATA_W-1:0] rd_want;
        if (!i_rst_n) begin
            safe_mask = SAFE_MASK_RST;
            arms_cfg  = ARMS_RST;
            for (int i = 0; i < MAX_ARMS; i++) begin
                arm_mode[i]  = '0;
                mode_seen[i] = 1'b0;
                arm_acked[i] = 1'b0;
            end
            in_flight = 1'b0;
            frozen    = 1'b0;
            interlock_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[APB_ADDR_W-1:2] == REG_SAFE_MASK) safe_mask = i_pwdata;
                    else arms_cfg = i_pwdata[ARMS_W-1:0];
                end else begin
                    rd_want = (i_paddr[APB_ADDR_W-1:2] == REG_SAFE_MASK) ?
                              APB_DATA_W'(safe_mask) : APB_DATA_W'(arms_cfg);
                    if (i_prdata !== rd_want) begin
                        $error("prdata: expected %0h, got %0h", rd_want, i_prdata);
                        fail_count++;
                    end
                end
            end
            if (i_evt.valid && i_evt.ready) begin
                interlock_results.insert(interlock_results.size(),
                                         interlock_step(t_cmd'(i_evt.cmd), i_evt.arm_index,
                                                        i_evt.mode_num,
                                                        i_evt.trajectory_empty));
            end
            if (i_res.valid && i_res.ready) begin
                if (interlock_results.size() == 0) begin
                    $error("result transaction with no event outstanding");
                    fail_count++;
                end else begin
                    want = interlock_results.pop_front();
                    if (i_res.forward_mask !== want.forward_mask) begin
                        $error("forward_mask: expected %0h, got %0h",
                               want.forward_mask, i_res.forward_mask);
                        fail_count++;
                    end
                    if (i_res.dropped !== want.dropped) begin
                        $error("dropped: expected %0b, got %0b", want.dropped, i_res.dropped);
                        fail_count++;
                    end
                    if (i_res.combined_ack !== want.combined_ack) begin
                        $error("combined_ack: expected %0b, got %0b",
                               want.combined_ack, i_res.combined_ack);
                        fail_count++;
                    end
                    if (i_res.freeze_report !== want.freeze_report) begin
                        $error("freeze_report: expected %0b, got %0b",
                               want.freeze_report, i_res.freeze_report);
                        fail_count++;
                    end
                    if (i_res.freeze !== want.freeze) begin
                        $error("freeze: expected %0b, got %0b", want.freeze, i_res.freeze);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= interlock_results.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> sim/tb_multi_arm_ack_barrier_interlock.sv
// ----------------------------------------------------------------------------
// tb_multi_arm_ack_barrier_interlock
// Drives events and register writes into the interlock. A directed sequence
// walks the drop, freeze, release, barrier and cancel paths; random segments
// then mix full arm/trajectory/ack flights with noise under several register
// settings and handshake pressure. The checker reports failures for the verdict.
// ----------------------------------------------------------------------------
module tb_multi_arm_ack_barrier_interlock;
    import mabi_pkg::*;

    localparam int unsigned ARMS_BUILT = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          pending;
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          items_sent;
    int          target;
    logic [31:0] cur_mask;
    logic [3:0]  cur_arms;

    mabi_evt_if evt_if ();
    mabi_res_if res_if ();

    multi_arm_ack_barrier_interlock #(
        .MAX_ARMS (ARMS_BUILT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mabi_checker #(
        .MAX_ARMS (ARMS_BUILT)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (evt_if),
        .i_res        (res_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // hold off the result side while hold_cycles runs down
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            res_if.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int unsigned eff_arms();
        if (cur_arms < 1) return 1;
        if (cur_arms > ARMS_BUILT) return ARMS_BUILT;
        return 32'(cur_arms);
    endfunction

    function automatic logic [IDX_W-1:0] rnd_idx();
        return IDX_W'($urandom_range(7));
    endfunction

    function automatic logic [MODE_W-1:0] rnd_mode();
        return MODE_W'($urandom_range(31));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [MODE_W-1:0] pick_safe_mode();
        logic [MODE_W-1:0] m;
        m = rnd_mode();
        if (cur_mask != 0) begin
            while (!cur_mask[m]) m = rnd_mode();
        end
        return m;
    endfunction

    task automatic send_event(input t_cmd c, input logic [IDX_W-1:0] idx,
                              input logic [MODE_W-1:0] mode, input logic empty);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            evt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        evt_if.valid            <= 1'b1;
        evt_if.cmd              <= c;
        evt_if.arm_index        <= idx;
        evt_if.mode_num         <= mode;
        evt_if.trajectory_empty <= empty;
        @(posedge i_clk);
        while (!evt_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_noise();
        send_event(t_cmd'($urandom_range(3)), rnd_idx(), rnd_mode(), rnd_bit());
    endtask

    task automatic apb_access(input t_reg_idx r, input logic wr, input logic [31:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(int'(r) * 4);
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        evt_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic configure(input logic [31:0] mask, input logic [3:0] arms);
        wait_idle();
        apb_access(REG_SAFE_MASK, 1'b1, mask);
        apb_access(REG_ARMS, 1'b1, 32'(arms));
        apb_access(REG_SAFE_MASK, 1'b0, '0);
        apb_access(REG_ARMS, 1'b0, '0);
        cur_mask = mask;
        cur_arms = arms;
    endtask

    // mode reports, maybe a tick, trajectory, acks, then maybe a cancel or tick
    task automatic run_flight();
        int unsigned n;
        int unsigned start;
        n = eff_arms();
        for (int i = 0; i < n; i++) begin
            send_event(CMD_MODE, IDX_W'(i),
                       ($urandom_range(9) == 0) ? rnd_mode() : pick_safe_mode(),
                       rnd_bit());
        end
        if ($urandom_range(3) == 0) send_event(CMD_TICK, rnd_idx(), rnd_mode(), rnd_bit());
        send_event(CMD_TRAJ, rnd_idx(), rnd_mode(), ($urandom_range(11) == 0));
        start = $urandom_range(n - 1);
        for (int i = 0; i < n; i++) begin
            send_event(CMD_ACK, IDX_W'((start + i) % n), rnd_mode(), rnd_bit());
            if ($urandom_range(5) == 0) send_event(CMD_ACK, rnd_idx(), rnd_mode(), rnd_bit());
        end
        send_event(CMD_ACK, IDX_W'($urandom_range(n - 1)), rnd_mode(), rnd_bit());
        case ($urandom_range(2))
            0: send_event(CMD_TRAJ, rnd_idx(), rnd_mode(), 1'b1);
            1: send_event(CMD_TICK, rnd_idx(), rnd_mode(), rnd_bit());
            default: ;
        endcase
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        evt_if.valid            = 1'b0;
        evt_if.cmd              = CMD_TRAJ;
        evt_if.arm_index        = '0;
        evt_if.mode_num         = '0;
        evt_if.trajectory_empty = 1'b0;
        res_if.ready            = 1'b0;
        send_idle_pct           = 15;
        recv_idle_pct           = 71;
        hold_cycles             = 0;
        items_sent              = 0;
        cur_mask                = SAFE_MASK_RST;
        cur_arms                = ARMS_RST;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk at the reset register values
        send_event(CMD_ACK,  3'd0, 5'd0,  1'b0);
        send_event(CMD_TRAJ, 3'd0, 5'd0,  1'b0);
        send_event(CMD_TICK, 3'd0, 5'd0,  1'b0);
        send_event(CMD_MODE, 3'd0, 5'd1,  1'b0);
        send_event(CMD_MODE, 3'd1, 5'd2,  1'b1);
        send_event(CMD_MODE, 3'd7, 5'd31, 1'b0);
        send_event(CMD_TICK, 3'd7, 5'd31, 1'b1);
        send_event(CMD_TRAJ, 3'd0, 5'd0,  1'b0);
        send_event(CMD_ACK,  3'd0, 5'd0,  1'b0);
        send_event(CMD_ACK,  3'd5, 5'd0,  1'b0);
        send_event(CMD_ACK,  3'd1, 5'd0,  1'b0);
        send_event(CMD_ACK,  3'd1, 5'd31, 1'b1);
        send_event(CMD_TRAJ, 3'd7, 5'd31, 1'b1);
        send_event(CMD_ACK,  3'd0, 5'd0,  1'b0);
        send_event(CMD_MODE, 3'd1, 5'd0,  1'b0);
        send_event(CMD_TRAJ, 3'd0, 5'd0,  1'b0);
        send_event(CMD_TICK, 3'd0, 5'd0,  1'b0);
        send_event(CMD_MODE, 3'd1, 5'd2,  1'b0);
        send_event(CMD_TRAJ, 3'd0, 5'd0,  1'b0);
        send_event(CMD_ACK,  3'd0, 5'd0,  1'b0);
        send_event(CMD_TICK, 3'd0, 5'd0,  1'b0);
        send_event(CMD_ACK,  3'd1, 5'd0,  1'b0);
        send_event(CMD_TICK, 3'd1, 5'd0,  1'b0);

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: configure(32'hFFFF_FFFF, 4'd8);
                1: configure(32'h0000_0000, 4'd0);
                2: configure($urandom, 4'd15);
                3: configure(32'h0000_0006, 4'd1);
                4: configure($urandom | 32'h1, 4'($urandom_range(8, 1)));
                default: configure(32'h8000_0001, 4'd3);
            endcase
            send_idle_pct = (seg < 2) ? 15 : (seg < 4) ? 71 : 0;
            recv_idle_pct = (seg < 2) ? 71 : (seg < 4) ? 15 : 0;
            if (seg == 1 || seg == 4) hold_cycles = 300;
            target = items_sent + 213;
            while (items_sent < target) begin
                if ($urandom_range(99) < 70) run_flight();
                else send_noise();
            end
        end

        wait_idle();
        repeat (5) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/mabi_pkg.sv
hdl/mabi_evt_if.sv
hdl/mabi_res_if.sv
hdl/multi_arm_ack_barrier_interlock.sv
sim/mabi_checker.sv
sim/tb_multi_arm_ack_barrier_interlock.sv
